@@ src/dual_hbridge_ramped_pwm_controller_top_assert.svh @@
// assertion macros for the dual h-bridge pwm controller
// used by dual_hbridge_ramped_pwm_controller_top; no other dependencies
`ifndef DUAL_HBRIDGE_RAMPED_PWM_CONTROLLER_TOP_ASSERT_SVH
`define DUAL_HBRIDGE_RAMPED_PWM_CONTROLLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define DHB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhb check failed");
// next-cycle implication, disabled during reset
`define DHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhb check failed");
`else
`define DHB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DHB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/dhb_pkg.sv @@
// shared types, codes and constants for the dual h-bridge pwm controller
// no dependencies
`default_nettype none

package dhb_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // request codes
    typedef enum logic [2:0] {
        REQ_SET_DUTY = 3'd0,
        REQ_TICK     = 3'd1,
        REQ_STOP     = 3'd2,
        REQ_ENABLE   = 3'd3,
        REQ_DISABLE  = 3'd4
    } req_code_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_DISABLED = 2'd2
    } rsp_status_t;

    // bridge input pin patterns, bit0 in1, bit1 in2
    typedef enum logic [1:0] {
        DIR_COAST = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_REV   = 2'd2,
        DIR_BRAKE = 2'd3
    } dir_t;

    // register word indexes
    typedef enum logic [2:0] {
        REG_MAX_DUTY  = 3'd0,
        REG_MIN_START = 3'd1,
        REG_RAMP_STEP = 3'd2,
        REG_LEFT_REV  = 3'd3,
        REG_RIGHT_REV = 3'd4
    } reg_idx_t;

    localparam logic [14:0] MAX_DUTY_RST  = 15'd1000;
    localparam logic [14:0] MIN_START_RST = 15'd0;
    localparam logic [14:0] RAMP_STEP_RST = 15'd1;

    typedef struct packed {
        logic [14:0] max_duty;
        logic [14:0] min_start_duty;
        logic [14:0] ramp_step;
        logic        left_reversed;
        logic        right_reversed;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [1:0]         motor_id;
        logic signed [15:0] duty;
        logic               brake;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         left_dir_pins;
        logic [1:0]         right_dir_pins;
        logic [14:0]        left_compare;
        logic [14:0]        right_compare;
        logic               standby_pin;
        logic signed [15:0] left_applied;
        logic signed [15:0] right_applied;
    } result_t;

    // one channel after a ramp tick
    typedef struct packed {
        logic signed [15:0] applied;
        logic [1:0]         pins;
        logic [14:0]        compare;
    } chan_drive_t;

endpackage

`default_nettype wire

@@ src/dhb_ifs.sv @@
// request and result channel interfaces, valid/ready handshake
// depends on dhb_pkg
`default_nettype none

interface dhb_req_if;
    import dhb_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [1:0]         motor_id;
    logic signed [15:0] duty;
    logic               brake;

    modport source (output valid, output req_type, output motor_id, output duty,
                    output brake, input ready);
    modport sink (input valid, input req_type, input motor_id, input duty,
                  input brake, output ready);
endinterface

interface dhb_rsp_if;
    import dhb_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [1:0]         left_dir_pins;
    logic [1:0]         right_dir_pins;
    logic [14:0]        left_compare;
    logic [14:0]        right_compare;
    logic               standby_pin;
    logic signed [15:0] left_applied;
    logic signed [15:0] right_applied;

    modport source (output valid, output status, output left_dir_pins,
                    output right_dir_pins, output left_compare, output right_compare,
                    output standby_pin, output left_applied, output right_applied,
                    input ready);
    modport sink (input valid, input status, input left_dir_pins,
                  input right_dir_pins, input left_compare, input right_compare,
                  input standby_pin, input left_applied, input right_applied,
                  output ready);
endinterface

`default_nettype wire

@@ src/dhb_apb_regs.sv @@
// apb configuration registers: duty limits, ramp step, reversal flags
// depends on dhb_pkg
`default_nettype none

module dhb_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dhb_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [dhb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [dhb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output dhb_pkg::cfg_t                          cfg
);
    import dhb_pkg::*;

    logic [2:0] idx;
    logic       wr_en;
    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MAX_DUTY:  cfg_next.max_duty       = pwdata[14:0];
                REG_MIN_START: cfg_next.min_start_duty = pwdata[14:0];
                REG_RAMP_STEP: cfg_next.ramp_step      = pwdata[14:0];
                REG_LEFT_REV:  cfg_next.left_reversed  = pwdata[0];
                REG_RIGHT_REV: cfg_next.right_reversed = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_duty       <= MAX_DUTY_RST;
            cfg_reg.min_start_duty <= MIN_START_RST;
            cfg_reg.ramp_step      <= RAMP_STEP_RST;
            cfg_reg.left_reversed  <= 1'b0;
            cfg_reg.right_reversed <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_MAX_DUTY:  prdata = {17'd0, cfg_reg.max_duty};
            REG_MIN_START: prdata = {17'd0, cfg_reg.min_start_duty};
            REG_RAMP_STEP: prdata = {17'd0, cfg_reg.ramp_step};
            REG_LEFT_REV:  prdata = {31'd0, cfg_reg.left_reversed};
            REG_RIGHT_REV: prdata = {31'd0, cfg_reg.right_reversed};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/dhb_chan.sv @@
// one channel's ramp toward target and bridge drive (pins, compare)
// depends on dhb_pkg
`default_nettype none

module dhb_chan (
    input  wire logic signed [15:0] applied,
    input  wire logic signed [15:0] target,
    input  wire logic [14:0]        step,
    input  wire logic               reversed,
    output dhb_pkg::chan_drive_t    drv
);
    import dhb_pkg::*;

    logic signed [17:0] a_ext;
    logic signed [17:0] t_ext;
    logic signed [17:0] step_ext;
    logic signed [17:0] up;
    logic signed [17:0] dn;
    logic signed [17:0] ramped;
    logic signed [16:0] logical;
    logic signed [16:0] phys;
    logic signed [16:0] mag;

    assign a_ext    = {{2{applied[15]}}, applied};
    assign t_ext    = {{2{target[15]}}, target};
    assign step_ext = {3'd0, step};
    assign up       = a_ext + step_ext;
    assign dn       = a_ext - step_ext;

    // step toward target, never past it
    always_comb
    begin
        if (a_ext < t_ext)
            ramped = (up > t_ext) ? t_ext : up;
        else if (a_ext > t_ext)
            ramped = (dn < t_ext) ? t_ext : dn;
        else
            ramped = a_ext;
    end

    // physical direction after reversal
    assign logical = ramped[16:0];
    assign phys    = reversed ? -logical : logical;
    assign mag     = phys[16] ? -phys : phys;

    // pins and saturated compare
    always_comb
    begin
        drv.applied = ramped[15:0];
        if (phys > 17'sd0)
            drv.pins = DIR_FWD;
        else if (phys < 17'sd0)
            drv.pins = DIR_REV;
        else
            drv.pins = DIR_COAST;
        drv.compare = (mag > 17'sd32767) ? 15'h7fff : mag[14:0];
    end

endmodule

`default_nettype wire

@@ src/dhb_core.sv @@
// channel state and request handling: set duty, tick, stop, enable, disable
// depends on dhb_pkg and dhb_chan
`default_nettype none

module dhb_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire dhb_pkg::item_t item,
    input  wire dhb_pkg::cfg_t  cfg,
    output dhb_pkg::result_t    result
);
    import dhb_pkg::*;

    logic signed [15:0] target_reg  [2];
    logic signed [15:0] target_next [2];
    logic signed [15:0] applied_reg [2];
    logic signed [15:0] applied_next[2];
    logic [1:0]         pins_reg    [2];
    logic [1:0]         pins_next   [2];
    logic [14:0]        cmp_reg     [2];
    logic [14:0]        cmp_next    [2];
    logic               standby_reg;
    logic               standby_next;
    logic [1:0]         status;
    chan_drive_t        drv_l;
    chan_drive_t        drv_r;

    logic signed [16:0] d_in;
    logic signed [16:0] lim;
    logic signed [16:0] ms;
    logic signed [16:0] d_clip;
    logic signed [16:0] d_final;

    // ramp and drive per channel
    dhb_chan u_chan_l (
        .applied  (applied_reg[0]),
        .target   (target_reg[0]),
        .step     (cfg.ramp_step),
        .reversed (cfg.left_reversed),
        .drv      (drv_l)
    );

    dhb_chan u_chan_r (
        .applied  (applied_reg[1]),
        .target   (target_reg[1]),
        .step     (cfg.ramp_step),
        .reversed (cfg.right_reversed),
        .drv      (drv_r)
    );

    // clamp requested duty, then raise small nonzero values to the start duty
    assign d_in = {item.duty[15], item.duty};
    assign lim  = {2'b00, cfg.max_duty};
    assign ms   = {2'b00, cfg.min_start_duty};

    always_comb
    begin
        if (d_in > lim)
            d_clip = lim;
        else if (d_in < -lim)
            d_clip = -lim;
        else
            d_clip = d_in;
        if (d_clip != 17'sd0 && d_clip < ms && d_clip > -ms)
            d_final = (d_clip > 17'sd0) ? ms : -ms;
        else
            d_final = d_clip;
    end

    // request decode and next state
    always_comb
    begin
        target_next  = target_reg;
        applied_next = applied_reg;
        pins_next    = pins_reg;
        cmp_next     = cmp_reg;
        standby_next = standby_reg;
        status       = ST_OK;
        case (item.req_type)
            REQ_SET_DUTY:
            begin
                if (item.motor_id[1])
                    status = ST_BAD_ID;
                else if (!standby_reg)
                    status = ST_DISABLED;
                else
                    target_next[item.motor_id[0]] = d_final[15:0];
            end
            REQ_TICK:
            begin
                applied_next[0] = drv_l.applied;
                pins_next[0]    = drv_l.pins;
                cmp_next[0]     = drv_l.compare;
                applied_next[1] = drv_r.applied;
                pins_next[1]    = drv_r.pins;
                cmp_next[1]     = drv_r.compare;
            end
            REQ_STOP:
            begin
                if (item.motor_id[1])
                begin
                    status = ST_BAD_ID;
                end
                else
                begin
                    target_next[item.motor_id[0]]  = 16'sd0;
                    applied_next[item.motor_id[0]] = 16'sd0;
                    cmp_next[item.motor_id[0]]     = 15'd0;
                    pins_next[item.motor_id[0]]    = item.brake ? DIR_BRAKE : DIR_COAST;
                end
            end
            REQ_ENABLE:
            begin
                standby_next = 1'b1;
            end
            REQ_DISABLE:
            begin
                target_next[0]  = 16'sd0;
                target_next[1]  = 16'sd0;
                applied_next[0] = 16'sd0;
                applied_next[1] = 16'sd0;
                cmp_next[0]     = 15'd0;
                cmp_next[1]     = 15'd0;
                pins_next[0]    = DIR_COAST;
                pins_next[1]    = DIR_COAST;
                standby_next    = 1'b0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // state registers, enable flag and standby line share one bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '{2{16'sd0}};
            applied_reg <= '{2{16'sd0}};
            pins_reg    <= '{2{DIR_COAST}};
            cmp_reg     <= '{2{15'd0}};
            standby_reg <= 1'b0;
        end
        else if (fire)
        begin
            target_reg  <= target_next;
            applied_reg <= applied_next;
            pins_reg    <= pins_next;
            cmp_reg     <= cmp_next;
            standby_reg <= standby_next;
        end
    end

    // result shows state after the request
    always_comb
    begin
        result.status         = status;
        result.left_dir_pins  = pins_next[0];
        result.right_dir_pins = pins_next[1];
        result.left_compare   = cmp_next[0];
        result.right_compare  = cmp_next[1];
        result.standby_pin    = standby_next;
        result.left_applied   = applied_next[0];
        result.right_applied  = applied_next[1];
    end

endmodule

`default_nettype wire

@@ src/dual_hbridge_ramped_pwm_controller_top.sv @@
// channel    dir   handshake      payload
// req        in    valid/ready    req_type, motor_id, duty, brake
// rsp        out   valid/ready    status, pins, compares, standby, applied duties
// apb        in    psel/penable   max_duty, min_start_duty, ramp_step, reversal flags
//
// each request passes from acceptance through the input register, then through the
// request logic into the result register
// one request per cycle sustained while results are taken; the input register drains as the result register frees
// a stalled result holds its register; the next request waits in the input register
// asynchronous active-low reset clears channel state and loads register defaults
//
// depends on dhb_pkg, dhb_ifs, dhb_apb_regs, dhb_core and the assertion header
`default_nettype none

`include "dual_hbridge_ramped_pwm_controller_top_assert.svh"

module dual_hbridge_ramped_pwm_controller_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    dhb_req_if.sink                                req,
    dhb_rsp_if.source                              rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dhb_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [dhb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [dhb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import dhb_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    s1_adv;
    logic    in_fire;
    result_t core_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    dhb_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake control
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign in_fire   = req.valid && req.ready;

    assign in_item.req_type = req.req_type;
    assign in_item.motor_id = req.motor_id;
    assign in_item.duty     = req.duty;
    assign in_item.brake    = req.brake;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= in_item;
    end

    dhb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_adv),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (core_res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_res_reg <= core_res;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_res_reg.status;
    assign rsp.left_dir_pins  = out_res_reg.left_dir_pins;
    assign rsp.right_dir_pins = out_res_reg.right_dir_pins;
    assign rsp.left_compare   = out_res_reg.left_compare;
    assign rsp.right_compare  = out_res_reg.right_compare;
    assign rsp.standby_pin    = out_res_reg.standby_pin;
    assign rsp.left_applied   = out_res_reg.left_applied;
    assign rsp.right_applied  = out_res_reg.right_applied;

    // zero compare exactly when the left bridge coasts or brakes
    `DHB_ASSERT_IMPLY(a_left_cmp_pins, clk, rst_n, rsp.valid, (rsp.left_compare == 15'd0) == (rsp.left_dir_pins == DIR_COAST || rsp.left_dir_pins == DIR_BRAKE))
    // same for the right bridge
    `DHB_ASSERT_IMPLY(a_right_cmp_pins, clk, rst_n, rsp.valid, (rsp.right_compare == 15'd0) == (rsp.right_dir_pins == DIR_COAST || rsp.right_dir_pins == DIR_BRAKE))
    // a disable leaves both channels stopped and the driver in standby
    `DHB_ASSERT_NEXT(a_disable_stop, clk, rst_n, s1_adv && s1_item_reg.req_type == REQ_DISABLE, rsp.valid && !rsp.standby_pin && rsp.left_compare == 15'd0 && rsp.right_compare == 15'd0)

endmodule

`default_nettype wire
